// File: rtl/core/sts_pkg.sv
`timescale 1ns / 1ps
package sts_pkg;
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;
	localparam logic [1:0] CMD_QUERY  = 2'd3;

	localparam logic [2:0] KIND_ADD    = 3'd0;
	localparam logic [2:0] KIND_REMOVE = 3'd1;
	localparam logic [2:0] KIND_QUERY  = 3'd2;
	localparam logic [2:0] KIND_TICK   = 3'd3;
	localparam logic [2:0] KIND_DONE   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic CFG_INTERVAL = 1'b0;
	localparam logic CFG_BUDGET   = 1'b1;

	localparam logic [16:0] TICK_CLAMP = 17'd2048;
	localparam logic [15:0] INTERVAL_RESET = 16'd819;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_DONE  = 6'b000100,
		S_URD   = 6'b001000,
		S_UWR   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;
endpackage

// File: rtl/core/staggered_tick_scheduler.sv
`timescale 1ns / 1ps
// Channel   | Ports                                               | Handshake
// command   | cmd, client_id, elapsed                             | start / busy
// config    | cfg_we, cfg_index, cfg_data                         | cfg_we
// result    | kind, status, slot, ticked_id, tick_time, tick_count, last | result_valid
// Add, remove and query scan the used slots one per cycle in S_SCAN, then pass S_DONE;
// the answer is on the ports in the cycle after S_DONE, when busy has dropped.
// Update spends the S_URD state on the first read, then walks one slot per cycle, the read
// of the next slot overlapping the write-back of the current one, and ends in S_FIN;
// the walk stops early when the budget ends it. A tick result is on the
// ports in the cycle after its write-back, the done result in the cycle after S_FIN.
// Reset clears valid bits and counters at once; no sweep.
// Results cannot be stalled; busy is already low in the cycle the last result is on the ports.
module staggered_tick_scheduler import sts_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] client_id,
	input  logic [15:0] elapsed,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output logic [2:0]  kind,
	output logic [1:0]  status,
	output logic [4:0]  slot,
	output logic [31:0] ticked_id,
	output logic [11:0] tick_time,
	output logic [5:0]  tick_count,
	output logic        last
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	state_t state_q;
	logic [15:0] interval_q;
	logic [5:0] budget_q;
	logic [SLOTS-1:0] valid_q;
	logic [CW-1:0] used_q, live_q, pos_q, done_cnt_q;
	logic [IW-1:0] cursor_q, idx_q, hit_q, free_q;
	logic hit_v_q, free_v_q;
	logic [1:0] cmd_q;
	logic [31:0] id_q;
	logic [15:0] elapsed_q;
	logic [5:0] ticked_q;

	logic [31:0] client_mem [SLOTS];
	logic [16:0] accum_mem [SLOTS];
	logic [31:0] client_rd_s1;
	logic [16:0] accum_rd_s1;
	logic rd_valid_s1;

	logic [IW-1:0] rd_addr;
	logic client_we, accum_we;
	logic [IW-1:0] wr_addr;
	logic [31:0] client_wd;
	logic [16:0] accum_wd;

	logic [16:0] sum;
	logic tick_now;
	logic [19:0] stag_prod;
	logic [IW-1:0] next_idx, idx_plus;
	logic [5:0] ticked_nx;
	logic budget_hit;

	logic add_full;
	logic [IW-1:0] add_slot;

	assign busy = (state_q != S_IDLE);
	assign sum = accum_rd_s1 + {1'b0, elapsed_q};
	assign tick_now = rd_valid_s1 && (sum >= {1'b0, interval_q});
	assign ticked_nx = ticked_q + 6'd1;
	assign budget_hit = (budget_q != 6'd0) && (ticked_nx >= budget_q);
	assign stag_prod = {16'd0, id_q[3:0]} * {4'd0, interval_q};
	assign idx_plus = idx_q + IW'(1);
	assign next_idx = ({{(CW-IW){1'b0}}, idx_q} + CW'(1) >= used_q) ? '0 : idx_plus;

	// result fields
	assign add_full = !hit_v_q && !free_v_q && (used_q == CW'(SLOTS));
	assign add_slot = hit_v_q ? ((free_v_q && free_q < hit_q) ? free_q : hit_q)
		: (free_v_q ? free_q : used_q[IW-1:0]);

	always_comb begin
		rd_addr = idx_q;
		if (state_q == S_UWR)
			rd_addr = next_idx;
		if (state_q == S_SCAN)
			rd_addr = idx_plus;
		if (state_q == S_IDLE)
			rd_addr = '0;
	end

	// memories: one write and one registered read port each
	always_ff @(posedge clk) begin
		if (client_we)
			client_mem[wr_addr] <= client_wd;
		if (accum_we)
			accum_mem[wr_addr] <= accum_wd;
		client_rd_s1 <= client_mem[rd_addr];
		accum_rd_s1 <= accum_mem[rd_addr];
	end

	always_comb begin
		client_we = 1'b0;
		accum_we = 1'b0;
		wr_addr = idx_q;
		client_wd = id_q;
		accum_wd = '0;
		if (state_q == S_DONE && cmd_q == CMD_ADD && !add_full) begin
			client_we = 1'b1;
			accum_we = 1'b1;
			wr_addr = add_slot;
			accum_wd = {1'b0, stag_prod[19:4]};
		end
		if (state_q == S_UWR && rd_valid_s1) begin
			accum_we = 1'b1;
			accum_wd = tick_now ? 17'd0 : sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			interval_q <= INTERVAL_RESET;
			budget_q <= '0;
			valid_q <= '0;
			used_q <= '0;
			live_q <= '0;
			cursor_q <= '0;
			result_valid <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_INTERVAL)
					interval_q <= cfg_data;
				else
					budget_q <= cfg_data[5:0];
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						id_q <= client_id;
						elapsed_q <= elapsed;
						idx_q <= '0;
						pos_q <= '0;
						hit_v_q <= 1'b0;
						free_v_q <= 1'b0;
						ticked_q <= '0;
						if (cmd == CMD_UPDATE) begin
							idx_q <= cursor_q;
							done_cnt_q <= '0;
							state_q <= (used_q == '0) ? S_FIN : S_URD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// one slot per cycle, client read registered
					if (pos_q == used_q) begin
						state_q <= S_DONE;
					end else begin
						pos_q <= pos_q + CW'(1);
						idx_q <= idx_plus;
					end
				end
				S_DONE: begin
					result_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				S_URD: state_q <= S_UWR;
				S_UWR: begin
					if (tick_now) begin
						result_valid <= 1'b1;
						ticked_q <= ticked_nx;
					end
					done_cnt_q <= done_cnt_q + CW'(1);
					idx_q <= next_idx;
					if (tick_now && budget_hit) begin
						cursor_q <= next_idx;
						state_q <= S_FIN;
					end else if (done_cnt_q + CW'(1) == used_q) begin
						cursor_q <= (cursor_q + IW'(1) >= used_q[IW-1:0] && used_q != CW'(SLOTS))
							? '0 : ({{(CW-IW){1'b0}}, cursor_q} + CW'(1) == used_q) ? '0
							: cursor_q + IW'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_UWR;
					end
				end
				S_FIN: begin
					result_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			rd_valid_s1 <= (state_q == S_URD || state_q == S_UWR) ? valid_q[rd_addr] : 1'b0;
			if (state_q == S_SCAN && pos_q != used_q) begin
				// compare happens on the registered read launched the cycle before
				if (valid_q[idx_q] && client_rd_s1 == id_q && !hit_v_q) begin
					hit_v_q <= 1'b1;
					hit_q <= idx_q;
				end
				if (!valid_q[idx_q] && !free_v_q) begin
					free_v_q <= 1'b1;
					free_q <= idx_q;
				end
			end
			if (state_q == S_DONE) begin
				if (cmd_q == CMD_ADD) begin
					if (!add_full) begin
						if (hit_v_q) begin
							// free the old slot; the id moves to the lowest free one if that lies below it, else keeps its slot
							valid_q[hit_q] <= 1'b0;
							valid_q[add_slot] <= 1'b1;
						end else begin
							valid_q[add_slot] <= 1'b1;
							if (!free_v_q)
								used_q <= used_q + CW'(1);
							live_q <= live_q + CW'(1);
						end
					end
				end else if (cmd_q == CMD_REMOVE && hit_v_q) begin
					valid_q[hit_q] <= 1'b0;
					live_q <= live_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		kind <= KIND_DONE;
		status <= ST_OK;
		slot <= '0;
		ticked_id <= '0;
		tick_time <= '0;
		tick_count <= ticked_q;
		last <= 1'b1;
		if (state_q == S_DONE) begin
			tick_count <= '0;
			ticked_id <= id_q;
			case (cmd_q)
				CMD_ADD: begin
					kind <= KIND_ADD;
					status <= add_full ? ST_FULL : ST_OK;
					slot <= add_full ? 5'd0 : 5'(add_slot);
				end
				CMD_REMOVE: begin
					kind <= KIND_REMOVE;
					status <= hit_v_q ? ST_OK : ST_NOTFOUND;
					slot <= hit_v_q ? 5'(hit_q) : 5'd0;
				end
				default: begin
					kind <= KIND_QUERY;
					status <= hit_v_q ? ST_OK : ST_NOTFOUND;
					slot <= hit_v_q ? 5'(hit_q) : 5'd0;
				end
			endcase
		end else if (state_q == S_UWR) begin
			kind <= KIND_TICK;
			slot <= 5'(idx_q);
			ticked_id <= client_rd_s1;
			tick_time <= (sum > TICK_CLAMP) ? 12'd2048 : sum[11:0];
			tick_count <= ticked_nx;
			last <= 1'b0;
		end
	end

	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("final result while busy");
	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(SLOTS))
		else $error("slot count overflow");
	a_live_cap: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= used_q)
		else $error("live count above used");
endmodule
